@@ hw/rtl/dual_port_tx_ring_with_admission_top_macros.svh @@
// Assertion helpers used by dptx_back; they expect clk and rst_n in scope.
`ifndef DUAL_PORT_TX_RING_WITH_ADMISSION_TOP_MACROS_SVH
`define DUAL_PORT_TX_RING_WITH_ADMISSION_TOP_MACROS_SVH

// Same-cycle implication.
`define DPTX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DPTX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dptx_pkg.sv @@
package dptx_pkg;

  localparam int LEN_W  = 10;
  localparam int BYTE_W = 8;
  localparam int RES_W  = 10;
  localparam int OP_W   = 2;
  localparam int ROUTE_W = 2;
  localparam int MASK_W = 2;

  localparam logic [OP_W-1:0] OP_HEADER = 2'd0;
  localparam logic [OP_W-1:0] OP_BYTE   = 2'd1;
  localparam logic [OP_W-1:0] OP_READY  = 2'd2;

  localparam logic [ROUTE_W-1:0] ROUTE_PORT0 = 2'd0;
  localparam logic [ROUTE_W-1:0] ROUTE_PORT1 = 2'd1;
  localparam logic [ROUTE_W-1:0] ROUTE_ALL   = 2'd2;
  localparam logic [ROUTE_W-1:0] ROUTE_NONE  = 2'd3;

  localparam logic REG_ROUTE   = 1'b0;
  localparam logic REG_RESERVE = 1'b1;

  localparam logic [ROUTE_W-1:0] ROUTE_RST   = ROUTE_ALL;
  localparam logic [RES_W-1:0]   RESERVE_RST = 10'd96;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_BYTE,
    KIND_READY,
    KIND_NOP
  } dptx_kind_t;

  typedef struct packed {
    dptx_kind_t        kind;
    logic [LEN_W-1:0]  msg_length;
    logic              stream_msg;
    logic [BYTE_W-1:0] data_byte;
    logic              ready_port;
  } dptx_cmd_t;

endpackage

@@ hw/rtl/dptx_front.sv @@
module dptx_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [dptx_pkg::OP_W-1:0]    in_operation,
  input  logic [dptx_pkg::LEN_W-1:0]   in_msg_length,
  input  logic                         in_stream_msg,
  input  logic [dptx_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                         in_ready_port,
  output logic                         cmd_valid,
  output dptx_pkg::dptx_cmd_t          cmd,
  input  logic                         cmd_take
);

  dptx_pkg::dptx_cmd_t q_r [2];
  logic                wp_r, wp_nxt;
  logic                rp_r, rp_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  dptx_pkg::dptx_kind_t kind;
  logic                push;
  logic                pop;

  // classify the operation code
  always_comb begin
    unique case (in_operation)
      dptx_pkg::OP_HEADER: kind = dptx_pkg::KIND_HEADER;
      dptx_pkg::OP_BYTE:   kind = dptx_pkg::KIND_BYTE;
      dptx_pkg::OP_READY:  kind = dptx_pkg::KIND_READY;
      default:             kind = dptx_pkg::KIND_NOP;
    endcase
  end

  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{kind:       kind,
                     msg_length: in_msg_length,
                     stream_msg: in_stream_msg,
                     data_byte:  in_data_byte,
                     ready_port: in_ready_port};
    end
  end

endmodule

@@ hw/rtl/dptx_back.sv @@
`include "dual_port_tx_ring_with_admission_top_macros.svh"

module dptx_back #(
  parameter int RING_DEPTH = 1024,
  parameter int PORT_COUNT = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [dptx_pkg::ROUTE_W-1:0]   route,
  input  logic [dptx_pkg::RES_W-1:0]     stream_reserve,
  input  logic                           cmd_valid,
  input  dptx_pkg::dptx_cmd_t            cmd,
  output logic                           cmd_take,
  output logic                           out_strobe,
  output logic                           out_tx_valid,
  output logic                           out_tx_port,
  output logic [dptx_pkg::BYTE_W-1:0]    out_tx_byte,
  output logic [dptx_pkg::MASK_W-1:0]    out_accepted_mask,
  output logic [dptx_pkg::MASK_W-1:0]    out_pending_mask
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CMP_W = (IDX_W > dptx_pkg::LEN_W + 1) ? IDX_W : dptx_pkg::LEN_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  logic [PORT_COUNT-1:0]            targets;
  logic [PORT_COUNT-1:0]            admit;
  logic [PORT_COUNT-1:0]            do_wr;
  logic [PORT_COUNT-1:0]            do_pop;
  logic [PORT_COUNT-1:0]            pend;
  logic [PORT_COUNT-1:0]            accepting_r, accepting_nxt;
  logic [dptx_pkg::LEN_W-1:0]       bytes_left_r, bytes_left_nxt;
  logic                             is_hdr, is_byte, is_ready;
  logic [CMP_W-1:0]                 len_ext, need_ext;
  logic [PORT_COUNT+1:0]            acc_pad, pend_pad;

  logic                             strobe_r;
  logic                             tx_valid_r;
  logic                             tx_port_r;
  logic [dptx_pkg::MASK_W-1:0]      acc_r;
  logic [dptx_pkg::MASK_W-1:0]      pend_r;
  logic [PORT_COUNT-1:0]            pop_sel_r;
  logic [dptx_pkg::BYTE_W-1:0]      rdata_r [PORT_COUNT];

  assign cmd_take = 1'b1;
  assign is_hdr   = cmd_valid && (cmd.kind == dptx_pkg::KIND_HEADER);
  assign is_byte  = cmd_valid && (cmd.kind == dptx_pkg::KIND_BYTE) && (bytes_left_r != '0);
  assign is_ready = cmd_valid && (cmd.kind == dptx_pkg::KIND_READY);
  assign len_ext  = CMP_W'(cmd.msg_length);
  assign need_ext = CMP_W'(cmd.msg_length) + CMP_W'(stream_reserve);

  for (genvar p = 0; p < PORT_COUNT; p++) begin : g_port
    logic [IDX_W-1:0]          wr_r, wr_nxt;
    logic [IDX_W-1:0]          rd_r, rd_nxt;
    logic [IDX_W-1:0]          cnt_r, cnt_nxt;
    logic [IDX_W-1:0]          free_space;
    logic [dptx_pkg::BYTE_W-1:0] mem [RING_DEPTH];

    assign targets[p] = (route == dptx_pkg::ROUTE_ALL) ||
                        (!route[1] && (32'(route[0]) == p));
    assign free_space = LAST_IDX - cnt_r;
    assign admit[p]   = (CMP_W'(free_space) >= len_ext) &&
                        (!cmd.stream_msg || (CMP_W'(free_space) >= need_ext));
    assign do_wr[p]   = is_byte && accepting_r[p] && (cnt_r != LAST_IDX);
    assign do_pop[p]  = is_ready && (32'(cmd.ready_port) == p) && (cnt_r != '0);

    always_comb begin
      wr_nxt  = wr_r;
      rd_nxt  = rd_r;
      cnt_nxt = cnt_r;
      if (do_wr[p]) begin
        wr_nxt  = (wr_r == LAST_IDX) ? '0 : wr_r + 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
      if (do_pop[p]) begin
        rd_nxt  = (rd_r == LAST_IDX) ? '0 : rd_r + 1'b1;
        cnt_nxt = cnt_r - 1'b1;
      end
    end

    assign pend[p] = (cnt_nxt != '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        wr_r  <= '0;
        rd_r  <= '0;
        cnt_r <= '0;
      end else begin
        wr_r  <= wr_nxt;
        rd_r  <= rd_nxt;
        cnt_r <= cnt_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (do_wr[p]) begin
        mem[wr_r] <= cmd.data_byte;
      end
      if (do_pop[p]) begin
        rdata_r[p] <= mem[rd_r];
      end
    end
  end

  always_comb begin
    accepting_nxt  = accepting_r;
    bytes_left_nxt = bytes_left_r;
    if (is_hdr) begin
      accepting_nxt  = targets & admit;
      bytes_left_nxt = cmd.msg_length;
    end else if (is_byte) begin
      bytes_left_nxt = bytes_left_r - 1'b1;
    end
  end

  assign acc_pad  = {2'b00, is_hdr ? accepting_nxt : {PORT_COUNT{1'b0}}};
  assign pend_pad = {2'b00, pend};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepting_r  <= '0;
      bytes_left_r <= '0;
      strobe_r     <= 1'b0;
      tx_valid_r   <= 1'b0;
      tx_port_r    <= 1'b0;
      acc_r        <= '0;
      pend_r       <= '0;
      pop_sel_r    <= '0;
    end else begin
      accepting_r  <= accepting_nxt;
      bytes_left_r <= bytes_left_nxt;
      strobe_r     <= cmd_valid;
      tx_valid_r   <= |do_pop;
      tx_port_r    <= (|do_pop) ? cmd.ready_port : 1'b0;
      acc_r        <= acc_pad[1:0];
      pend_r       <= pend_pad[1:0];
      pop_sel_r    <= do_pop;
    end
  end

  always_comb begin
    out_tx_byte = '0;
    for (int p = 0; p < PORT_COUNT; p++) begin
      if (pop_sel_r[p]) begin
        out_tx_byte = rdata_r[p];
      end
    end
  end

  assign out_strobe        = strobe_r;
  assign out_tx_valid      = tx_valid_r;
  assign out_tx_port       = tx_port_r;
  assign out_accepted_mask = acc_r;
  assign out_pending_mask  = pend_r;

  `DPTX_ASSERT_NEXT(a_cmd_gives_result, cmd_valid, strobe_r, "command produced no result")
  `DPTX_ASSERT_NOW(a_pop_no_accept, strobe_r && tx_valid_r, acc_r == '0, "pop with accept mask")
  `DPTX_ASSERT_NEXT(a_byte_counts_down, is_byte,
                    bytes_left_r == $past(bytes_left_r) - 1'b1, "byte count not decremented")

endmodule

@@ hw/rtl/dual_port_tx_ring_with_admission_top.sv @@
// Transmit byte rings for PORT_COUNT serial ports, each RING_DEPTH entries (holds up to
// RING_DEPTH-1 bytes), with admission control on message headers. Pulse start with a
// transaction while busy is low; every accepted transaction yields exactly one result.
// The command queue registers the accepted transaction and the back end registers its
// result, marked by out_strobe; the receiver cannot stall it, so capture it on that
// cycle. The block sustains one transaction per cycle: the back end executes one command
// per cycle against the ring indices and fill counts, and a ring read is registered
// before the byte appears on out_tx_byte. A two-entry command queue sits between the
// front and the back end; the back end drains one command every cycle, so the queue
// never fills and busy stays low. No clearing pass runs after reset: ring entries are
// read only after they were written. Change route and stream_reserve over the APB port
// only while no transaction is in flight.
module dual_port_tx_ring_with_admission_top #(
  parameter int RING_DEPTH = 1024,
  parameter int PORT_COUNT = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [dptx_pkg::OP_W-1:0]     in_operation,
  input  logic [dptx_pkg::LEN_W-1:0]    in_msg_length,
  input  logic                          in_stream_msg,
  input  logic [dptx_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                          in_ready_port,
  // result channel
  output logic                          out_strobe,
  output logic                          out_tx_valid,
  output logic                          out_tx_port,
  output logic [dptx_pkg::BYTE_W-1:0]   out_tx_byte,
  output logic [dptx_pkg::MASK_W-1:0]   out_accepted_mask,
  output logic [dptx_pkg::MASK_W-1:0]   out_pending_mask,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [dptx_pkg::ROUTE_W-1:0] route_r, route_nxt;
  logic [dptx_pkg::RES_W-1:0]   reserve_r, reserve_nxt;
  logic                         cfg_wr;
  logic                         cmd_valid;
  logic                         cmd_take;
  dptx_pkg::dptx_cmd_t          cmd;

  // APB: pready is tied high, so no transfer is stalled; decode the register by word address
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    route_nxt   = route_r;
    reserve_nxt = reserve_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        dptx_pkg::REG_ROUTE:   route_nxt   = pwdata[dptx_pkg::ROUTE_W-1:0];
        dptx_pkg::REG_RESERVE: reserve_nxt = pwdata[dptx_pkg::RES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dptx_pkg::REG_ROUTE:   prdata = 32'(route_r);
      dptx_pkg::REG_RESERVE: prdata = 32'(reserve_r);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_r   <= dptx_pkg::ROUTE_RST;
      reserve_r <= dptx_pkg::RESERVE_RST;
    end else begin
      route_r   <= route_nxt;
      reserve_r <= reserve_nxt;
    end
  end

  // front end: take the transaction, classify it, queue it
  dptx_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_msg_length (in_msg_length),
    .in_stream_msg (in_stream_msg),
    .in_data_byte  (in_data_byte),
    .in_ready_port (in_ready_port),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take)
  );

  // back end: admit headers, fill and drain the rings, register the result
  dptx_back #(
    .RING_DEPTH (RING_DEPTH),
    .PORT_COUNT (PORT_COUNT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .route             (route_r),
    .stream_reserve    (reserve_r),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_take          (cmd_take),
    .out_strobe        (out_strobe),
    .out_tx_valid      (out_tx_valid),
    .out_tx_port       (out_tx_port),
    .out_tx_byte       (out_tx_byte),
    .out_accepted_mask (out_accepted_mask),
    .out_pending_mask  (out_pending_mask)
  );

endmodule
